/* hdl/hsv_to_rgba_converter_macros.svh */
// assertion macros shared by the converter modules
`ifndef HSV_TO_RGBA_CONVERTER_MACROS_SVH
`define HSV_TO_RGBA_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define H2R_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h2r assertion failed");

// next-cycle implication
`define H2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h2r assertion failed");

`else

`define H2R_ASSERT_IMPL(label, clk, rst, ante, cons)
`define H2R_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/h2r_pkg.sv */
package h2r_pkg;

   // hue and channel constants
   localparam logic [8:0]  HUE_TURN    = 9'd360;
   localparam logic [5:0]  SECTOR_SPAN = 6'd60;
   localparam logic [7:0]  CHAN_MAX    = 8'd255;
   localparam logic [13:0] FRAC_DENOM  = 14'd15300;

   // reciprocal multipliers for exact floor division
   // floor(x / 255) = (x * 65794) >> 24 for x < 2^16
   localparam logic [16:0] M_RECIP = 17'd65794;
   localparam int          M_SHIFT = 24;
   // floor(x / 15300) = (x * 4491470) >> 36 for x < 2^22
   localparam logic [22:0] F_RECIP = 23'd4491470;
   localparam int          F_SHIFT = 36;

   // 60 degree hue sectors
   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } h2r_sector_type;

   // raw or wrapped pixel
   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] alpha;
   } h2r_pix_type;

   // pixel after sector split
   typedef struct packed {
      h2r_sector_type sector;
      logic [5:0]     rem;
      logic [7:0]     sat;
      logic [7:0]     val;
      logic [7:0]     alpha;
   } h2r_sect_type;

   // pixel with final m, n, k terms
   typedef struct packed {
      h2r_sector_type sector;
      logic           zero_sat;
      logic [7:0]     val;
      logic [7:0]     alpha;
      logic [7:0]     m;
      logic [7:0]     n;
      logic [7:0]     k;
   } h2r_term_type;

endpackage

/* hdl/h2r_ifs.sv */
// request channel: one hsv pixel with alpha
interface h2r_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;
   logic [7:0] alpha_in;

   modport source (output valid, output hue, output saturation, output brightness,
                   output alpha_in, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input alpha_in, output ready);
endinterface

// response channel: packed rgba word
interface h2r_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] rgba_word;

   modport source (output valid, output rgba_word, input ready);
   modport sink   (input valid, input rgba_word, output ready);
endinterface

/* hdl/h2r_sector.sv */
`include "hsv_to_rgba_converter_macros.svh"

module h2r_sector (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  h2r_pkg::h2r_pix_type  in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output h2r_pkg::h2r_sect_type out_data,
   input  logic                  out_ready
);
   import h2r_pkg::*;

   logic           st1_valid_ff;
   h2r_pix_type    st1_data_ff;
   h2r_pix_type    st1_data_in;
   logic           st1_ready;
   logic           st2_valid_ff;
   h2r_sect_type   st2_data_ff;
   h2r_sect_type   st2_data_in;
   logic           st2_ready;
   logic [2:0]     sec_count;
   h2r_sector_type sec_code;
   logic [8:0]     sec_base;
   logic           out_stall;

   // stage readiness, bubbles collapse
   assign st1_ready = !st1_valid_ff || st2_ready;
   assign st2_ready = !st2_valid_ff || out_ready;
   assign in_ready  = st1_ready;

   // stage 1: bring hue into 0..359
   always_comb begin
      st1_data_in = in_data;
      if (in_data.hue >= HUE_TURN) begin
         st1_data_in.hue = in_data.hue - HUE_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else if (st1_ready) begin
         st1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (st1_ready && in_valid) begin
         st1_data_ff <= st1_data_in;
      end
   end

   // stage 2: sector by parallel compares, remainder by constant base
   assign sec_count = 3'(st1_data_ff.hue >= 9'd60) + 3'(st1_data_ff.hue >= 9'd120)
                    + 3'(st1_data_ff.hue >= 9'd180) + 3'(st1_data_ff.hue >= 9'd240)
                    + 3'(st1_data_ff.hue >= 9'd300);
   assign sec_code = h2r_sector_type'(sec_count);

   always_comb begin
      case (sec_code)
         SEC_R_TO_Y: sec_base = 9'd0;
         SEC_Y_TO_G: sec_base = 9'd60;
         SEC_G_TO_C: sec_base = 9'd120;
         SEC_C_TO_B: sec_base = 9'd180;
         SEC_B_TO_M: sec_base = 9'd240;
         default:    sec_base = 9'd300;
      endcase
   end

   always_comb begin
      st2_data_in.sector = sec_code;
      st2_data_in.rem    = 6'(st1_data_ff.hue - sec_base);
      st2_data_in.sat    = st1_data_ff.sat;
      st2_data_in.val    = st1_data_ff.val;
      st2_data_in.alpha  = st1_data_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else if (st2_ready) begin
         st2_valid_ff <= st1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st2_ready && st1_valid_ff) begin
         st2_data_ff <= st2_data_in;
      end
   end

   assign out_valid = st2_valid_ff;
   assign out_data  = st2_data_ff;

   // checks
   assign out_stall = st2_valid_ff && !out_ready;

   `H2R_ASSERT_IMPL(a_hue_wrapped, clock, reset, st1_valid_ff, st1_data_ff.hue < HUE_TURN)
   `H2R_ASSERT_IMPL(a_rem_range, clock, reset, st2_valid_ff, st2_data_ff.rem < SECTOR_SPAN)
   `H2R_ASSERT_NEXT(a_stall_hold, clock, reset, out_stall, st2_valid_ff && $stable(st2_data_ff))

endmodule

/* hdl/h2r_terms.sv */
`include "hsv_to_rgba_converter_macros.svh"

module h2r_terms (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  h2r_pkg::h2r_sect_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output h2r_pkg::h2r_term_type out_data,
   input  logic                  out_ready
);
   import h2r_pkg::*;

   // stage 3 fields
   logic           st3_valid_ff;
   h2r_sector_type st3_sector_ff;
   logic           st3_zero_ff;
   logic [7:0]     st3_val_ff;
   logic [7:0]     st3_alpha_ff;
   logic [13:0]    st3_srem_ff;
   logic [13:0]    st3_scomp_ff;
   logic [15:0]    st3_mnum_ff;
   logic [13:0]    st3_srem_in;
   logic [13:0]    st3_scomp_in;
   logic [15:0]    st3_mnum_in;
   logic           st3_ready;
   // stage 4 fields
   logic           st4_valid_ff;
   h2r_sector_type st4_sector_ff;
   logic           st4_zero_ff;
   logic [7:0]     st4_val_ff;
   logic [7:0]     st4_alpha_ff;
   logic [21:0]    st4_nnum_ff;
   logic [21:0]    st4_knum_ff;
   logic [7:0]     st4_m_ff;
   logic [21:0]    st4_nnum_in;
   logic [21:0]    st4_knum_in;
   logic [32:0]    m_prod;
   logic           st4_ready;
   // stage 5
   logic           st5_valid_ff;
   h2r_term_type   st5_data_ff;
   h2r_term_type   st5_data_in;
   logic [44:0]    n_prod;
   logic [44:0]    k_prod;
   logic           st5_ready;
   // check helpers
   logic           terms_bounded;
   logic           mnum_bounded;

   assign st3_ready = !st3_valid_ff || st4_ready;
   assign st4_ready = !st4_valid_ff || st5_ready;
   assign st5_ready = !st5_valid_ff || out_ready;
   assign in_ready  = st3_ready;

   // stage 3: s*rem, s*(60-rem), v*(255-s)
   assign st3_srem_in  = 14'(in_data.sat) * 14'(in_data.rem);
   assign st3_scomp_in = 14'(in_data.sat) * 14'(SECTOR_SPAN - in_data.rem);
   assign st3_mnum_in  = 16'(in_data.val) * 16'(CHAN_MAX - in_data.sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end else if (st3_ready) begin
         st3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (st3_ready && in_valid) begin
         st3_sector_ff <= in_data.sector;
         st3_zero_ff   <= (in_data.sat == 8'd0);
         st3_val_ff    <= in_data.val;
         st3_alpha_ff  <= in_data.alpha;
         st3_srem_ff   <= st3_srem_in;
         st3_scomp_ff  <= st3_scomp_in;
         st3_mnum_ff   <= st3_mnum_in;
      end
   end

   // stage 4: n and k numerators, m by reciprocal of 255
   assign st4_nnum_in = 22'(st3_val_ff) * 22'(FRAC_DENOM - st3_srem_ff);
   assign st4_knum_in = 22'(st3_val_ff) * 22'(FRAC_DENOM - st3_scomp_ff);
   assign m_prod      = 33'(st3_mnum_ff) * 33'(M_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         st4_valid_ff <= 1'b0;
      end else if (st4_ready) begin
         st4_valid_ff <= st3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st4_ready && st3_valid_ff) begin
         st4_sector_ff <= st3_sector_ff;
         st4_zero_ff   <= st3_zero_ff;
         st4_val_ff    <= st3_val_ff;
         st4_alpha_ff  <= st3_alpha_ff;
         st4_nnum_ff   <= st4_nnum_in;
         st4_knum_ff   <= st4_knum_in;
         st4_m_ff      <= m_prod[M_SHIFT +: 8];
      end
   end

   // stage 5: n and k by reciprocal of 15300
   assign n_prod = 45'(st4_nnum_ff) * 45'(F_RECIP);
   assign k_prod = 45'(st4_knum_ff) * 45'(F_RECIP);

   always_comb begin
      st5_data_in.sector   = st4_sector_ff;
      st5_data_in.zero_sat = st4_zero_ff;
      st5_data_in.val      = st4_val_ff;
      st5_data_in.alpha    = st4_alpha_ff;
      st5_data_in.m        = st4_m_ff;
      st5_data_in.n        = n_prod[F_SHIFT +: 8];
      st5_data_in.k        = k_prod[F_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st5_valid_ff <= 1'b0;
      end else if (st5_ready) begin
         st5_valid_ff <= st4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st5_ready && st4_valid_ff) begin
         st5_data_ff <= st5_data_in;
      end
   end

   assign out_valid = st5_valid_ff;
   assign out_data  = st5_data_ff;

   // checks: every term is bounded by the value channel
   assign terms_bounded = (st5_data_ff.m <= st5_data_ff.val)
                       && (st5_data_ff.n <= st5_data_ff.val)
                       && (st5_data_ff.k <= st5_data_ff.val);
   assign mnum_bounded  = st3_mnum_ff <= 16'(st3_val_ff) * 16'(CHAN_MAX);

   `H2R_ASSERT_IMPL(a_terms_bounded, clock, reset, st5_valid_ff, terms_bounded)
   `H2R_ASSERT_IMPL(a_mnum_bounded, clock, reset, st3_valid_ff, mnum_bounded)

endmodule

/* hdl/hsv_to_rgba_converter.sv */
// HSV to RGBA pixel converter. One pixel enters per clock unless back-pressure
// holds it, and the packed word (red 31-24, green 23-16, blue 15-8, alpha 7-0)
// leaves through six register stages: hue wrap, sector split, saturation
// products, value products with the divide by 255, the divide by 15300 done
// as a reciprocal multiply, and the final channel swizzle. Each stage holds
// its transaction under back-pressure and an empty stage still fills, so the
// block keeps taking pixels while a word waits at rsp_if until its stages fill.
`include "hsv_to_rgba_converter_macros.svh"

module hsv_to_rgba_converter (
   input logic       clock,
   input logic       reset,
   h2r_req_if.sink   req_if,
   h2r_rsp_if.source rsp_if
);
   import h2r_pkg::*;

   h2r_pix_type  req_data;
   logic         sec_valid;
   h2r_sect_type sec_data;
   logic         sec_ready;
   logic         term_valid;
   h2r_term_type term_data;
   logic         term_ready;
   logic         out_valid_ff;
   logic [31:0]  rgba_ff;
   logic [31:0]  rgba_in;
   logic [7:0]   red;
   logic [7:0]   green;
   logic [7:0]   blue;
   logic         out_stall;
   logic         term_load;

   // request transaction into the pipeline
   always_comb begin
      req_data.hue   = req_if.hue;
      req_data.sat   = req_if.saturation;
      req_data.val   = req_if.brightness;
      req_data.alpha = req_if.alpha_in;
   end

   h2r_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_data   (req_data),
      .in_ready  (req_if.ready),
      .out_valid (sec_valid),
      .out_data  (sec_data),
      .out_ready (sec_ready)
   );

   h2r_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_data   (sec_data),
      .in_ready  (sec_ready),
      .out_valid (term_valid),
      .out_data  (term_data),
      .out_ready (term_ready)
   );

   // sector swizzle, grey when saturation is zero
   always_comb begin
      if (term_data.zero_sat) begin
         red   = term_data.val;
         green = term_data.val;
         blue  = term_data.val;
      end else begin
         unique case (term_data.sector)
            SEC_R_TO_Y: begin
               red = term_data.val; green = term_data.k;   blue = term_data.m;
            end
            SEC_Y_TO_G: begin
               red = term_data.n;   green = term_data.val; blue = term_data.m;
            end
            SEC_G_TO_C: begin
               red = term_data.m;   green = term_data.val; blue = term_data.k;
            end
            SEC_C_TO_B: begin
               red = term_data.m;   green = term_data.n;   blue = term_data.val;
            end
            SEC_B_TO_M: begin
               red = term_data.k;   green = term_data.m;   blue = term_data.val;
            end
            default: begin
               red = term_data.val; green = term_data.m;   blue = term_data.n;
            end
         endcase
      end
   end

   assign rgba_in    = {red, green, blue, term_data.alpha};
   assign term_ready = !out_valid_ff || rsp_if.ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (term_ready) begin
         out_valid_ff <= term_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (term_ready && term_valid) begin
         rgba_ff <= rgba_in;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.rgba_word = rgba_ff;

   // checks
   assign out_stall = out_valid_ff && !rsp_if.ready;
   assign term_load = term_valid && term_ready;

   `H2R_ASSERT_NEXT(a_out_hold, clock, reset, out_stall, out_valid_ff && $stable(rgba_ff))
   `H2R_ASSERT_NEXT(a_out_load, clock, reset, term_load, out_valid_ff && rgba_ff == $past(rgba_in))

endmodule

/* sim/hsv_to_rgba_converter_tb.sv */
`timescale 1ns / 1ps

module hsv_to_rgba_converter_tb;
   import h2r_pkg::*;

   localparam int RANDOM_PIXELS = 550;
   localparam int HOLD_AT       = 280;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 16;
   localparam int DIRECTED_ROWS = 23;

   // one row of directed stimulus, with a typed-in word where it is obvious
   typedef struct packed {
      logic [8:0]  hue;
      logic [7:0]  sat;
      logic [7:0]  val;
      logic [7:0]  alpha;
      logic        known;
      logic [31:0] word;
   } pixel_row_type;

   logic clock;
   logic reset;

   h2r_req_if req_chan ();
   h2r_rsp_if rsp_chan ();

   hsv_to_rgba_converter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   logic [31:0] offered_word;
   logic [31:0] expected_words [$];
   int          mismatch_count = 0;
   int          items_sent;
   int          idle_cycles = 0;
   bit          hold_done = 1'b0;

   pixel_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // all zero, and every field at its top
      '{9'd0,   8'd0,   8'd0,   8'h00, 1'b1, 32'h0000_0000},
      '{9'd511, 8'd255, 8'd255, 8'hFF, 1'b0, 32'h0},
      // pure primaries, then the first two of these hues past a full turn
      '{9'd0,   8'd255, 8'd255, 8'hA5, 1'b1, 32'hFF00_00A5},
      '{9'd120, 8'd255, 8'd255, 8'h5A, 1'b1, 32'h00FF_005A},
      '{9'd240, 8'd255, 8'd255, 8'h00, 1'b1, 32'h0000_FF00},
      '{9'd360, 8'd255, 8'd255, 8'h01, 1'b1, 32'hFF00_0001},
      '{9'd480, 8'd255, 8'd255, 8'hFF, 1'b1, 32'h00FF_00FF},
      // zero saturation gives grey whatever the hue
      '{9'd100, 8'd0,   8'hC3,  8'h3C, 1'b1, 32'hC3C3_C33C},
      '{9'd511, 8'd0,   8'd255, 8'h00, 1'b1, 32'hFFFF_FF00},
      // zero value gives black
      '{9'd300, 8'd128, 8'd0,   8'h7E, 1'b1, 32'h0000_007E},
      // sector starts and ends, then mid-sector hues
      '{9'd60,  8'd255, 8'd255, 8'h11, 1'b0, 32'h0},
      '{9'd180, 8'd255, 8'd255, 8'h22, 1'b0, 32'h0},
      '{9'd300, 8'd255, 8'd255, 8'h33, 1'b0, 32'h0},
      '{9'd59,  8'd255, 8'd255, 8'h44, 1'b0, 32'h0},
      '{9'd119, 8'd200, 8'd180, 8'h55, 1'b0, 32'h0},
      '{9'd179, 8'd1,   8'd255, 8'h66, 1'b0, 32'h0},
      '{9'd239, 8'd100, 8'd37,  8'h77, 1'b0, 32'h0},
      '{9'd299, 8'd255, 8'd128, 8'h88, 1'b0, 32'h0},
      '{9'd359, 8'd77,  8'd250, 8'h99, 1'b0, 32'h0},
      '{9'd419, 8'd255, 8'd255, 8'hAA, 1'b0, 32'h0},
      '{9'd256, 8'd170, 8'd85,  8'hBB, 1'b0, 32'h0},
      '{9'd45,  8'd255, 8'd1,   8'hCC, 1'b0, 32'h0},
      '{9'd330, 8'd254, 8'd254, 8'hDD, 1'b0, 32'h0}
   };

   // hsv plus alpha to packed rgba
   function automatic logic [31:0] predict_rgba(input logic [8:0] hue,
                                               input logic [7:0] sat,
                                               input logic [7:0] val,
                                               input logic [7:0] alpha);
      int unsigned    turn;
      int unsigned    span;
      int unsigned    chan;
      int unsigned    denom;
      int unsigned    h;
      int unsigned    rem;
      int unsigned    v;
      int unsigned    s;
      h2r_sector_type sector;
      logic [7:0]     m, n, k, r, g, b;
      turn  = int'(HUE_TURN);
      span  = int'(SECTOR_SPAN);
      chan  = int'(CHAN_MAX);
      denom = int'(FRAC_DENOM);
      v     = val;
      s     = sat;
      h     = hue;
      if (h >= turn) h = h - turn;
      if (s == 0) begin
         r = val;
         g = val;
         b = val;
      end else begin
         sector = h2r_sector_type'(h / span);
         rem    = h % span;
         m = 8'((v * (chan - s)) / chan);
         n = 8'((v * (denom - s * rem)) / denom);
         k = 8'((v * (denom - s * (span - rem))) / denom);
         case (sector)
            SEC_R_TO_Y: begin r = val; g = k;   b = m;   end
            SEC_Y_TO_G: begin r = n;   g = val; b = m;   end
            SEC_G_TO_C: begin r = m;   g = val; b = k;   end
            SEC_C_TO_B: begin r = m;   g = n;   b = val; end
            SEC_B_TO_M: begin r = k;   g = m;   b = val; end
            default:    begin r = val; g = m;   b = n;   end
         endcase
      end
      return {r, g, b, alpha};
   endfunction

   // mostly no gap, sometimes a few cycles, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hue biased toward sector edges and the wrap region
   function automatic logic [8:0] pick_hue();
      logic [8:0] edges [0:11];
      edges = '{9'd0, 9'd59, 9'd60, 9'd119, 9'd120, 9'd239,
                9'd240, 9'd359, 9'd360, 9'd419, 9'd420, 9'd511};
      if ($urandom_range(0, 99) < 75) return 9'($urandom_range(0, 511));
      return edges[$urandom_range(0, 11)];
   endfunction

   function automatic logic [7:0] pick_level(input int low_pct, input int high_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < low_pct) return 8'd0;
      if (roll < low_pct + high_pct) return 8'd255;
      if (roll < low_pct + high_pct + 5) return 8'd1;
      return 8'($urandom_range(0, 255));
   endfunction

   // offer one pixel until taken, then idle for gap cycles
   task automatic drive_pixel(input logic [8:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input logic [7:0] alpha,
                              input logic [31:0] word, input int gap);
      req_chan.valid      <= 1'b1;
      req_chan.hue        <= hue;
      req_chan.saturation <= sat;
      req_chan.brightness <= val;
      req_chan.alpha_in   <= alpha;
      offered_word        <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // track accepted pixels and check returned words in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) expected_words.push_back(offered_word);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $error("rgba_word %h arrived with no pixel outstanding", rsp_chan.rgba_word);
               mismatch_count++;
            end else begin
               if (rsp_chan.rgba_word !== expected_words[0]) begin
                  $error("rgba_word expected %h actual %h",
                         expected_words[0], rsp_chan.rgba_word);
                  mismatch_count++;
               end
               void'(expected_words.pop_front());
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("hsv_to_rgba_converter verification failed");
         $finish;
      end
   end

   // response side: random stalls plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            int high_run;
            int low_run;
            high_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 100)
                                                   : $urandom_range(1, 20);
            low_run  = pick_gap();
            rsp_chan.ready <= 1'b1;
            repeat (high_run) @(posedge clock);
            if (low_run > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (low_run) @(posedge clock);
            end
         end
      end
   end

   // request side and end of run
   initial begin
      items_sent          = 0;
      offered_word        = '0;
      req_chan.valid      = 1'b0;
      req_chan.hue        = '0;
      req_chan.saturation = '0;
      req_chan.brightness = '0;
      req_chan.alpha_in   = '0;
      reset               = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (directed_rows[i]) begin
         pixel_row_type row;
         logic [31:0]   word;
         row  = directed_rows[i];
         word = row.known ? row.word : predict_rgba(row.hue, row.sat, row.val, row.alpha);
         drive_pixel(row.hue, row.sat, row.val, row.alpha, word, pick_gap());
      end

      // random pixels, with a back-to-back burst for pixels 100 to 179
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         logic [8:0] hue;
         logic [7:0] sat;
         logic [7:0] val;
         logic [7:0] alpha;
         int         gap;
         hue   = pick_hue();
         sat   = pick_level(15, 15);
         val   = pick_level(10, 10);
         alpha = 8'($urandom_range(0, 255));
         gap   = (i >= 100 && i < 180) ? 0 : pick_gap();
         drive_pixel(hue, sat, val, alpha, predict_rgba(hue, sat, val, alpha), gap);
      end
      req_chan.valid <= 1'b0;

      // drain
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("hsv_to_rgba_converter verification clean");
      else
         $display("hsv_to_rgba_converter verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/h2r_pkg.sv
hdl/h2r_ifs.sv
hdl/h2r_sector.sv
hdl/h2r_terms.sv
hdl/hsv_to_rgba_converter.sv
sim/hsv_to_rgba_converter_tb.sv
